FILE: rtl/core/sfd_pkg.sv
package sfd_pkg;

    localparam logic [7:0] FRAME_END       = 8'hC0;
    localparam logic [7:0] FRAME_ESC       = 8'hDB;
    localparam logic [7:0] TRANS_FRAME_END = 8'hDC;
    localparam logic [7:0] TRANS_FRAME_ESC = 8'hDD;

    localparam int unsigned CFG_W             = 13;
    localparam int unsigned CFG_MAX_LEN_RESET = 4096;
    localparam int unsigned INDEX_W           = 12;
    localparam int unsigned LENGTH_W          = 13;
    localparam int unsigned COUNT_OUT_W       = 32;

    typedef enum logic [1:0] {
        EV_DATA     = 2'd0,
        EV_DONE     = 2'd1,
        EV_DROP_OVF = 2'd2,
        EV_DROP_ESC = 2'd3
    } t_event;

    // frame state seen by the byte decoder
    typedef struct packed {
        logic synced;
        logic esc_pending;
        logic fill_nonzero;
        logic fill_at_cap;
    } t_frame_status;

    // what one byte does to the frame state and the result
    typedef struct packed {
        logic       emit;
        t_event     ev;
        logic [7:0] data;
        logic       clr_fill;
        logic       inc_fill;
        logic       set_sync;
        logic       clr_sync;
        logic       set_esc;
        logic       clr_esc;
        logic       inc_done;
        logic       inc_drop;
    } t_step_ctl;

endpackage

FILE: rtl/core/sfd_byte_decode.sv
module sfd_byte_decode (
    input  logic [7:0]             i_byte,
    input  sfd_pkg::t_frame_status i_status,
    output sfd_pkg::t_step_ctl     o_ctl
);

    logic       put;
    logic [7:0] put_data;

    always_comb begin
        o_ctl    = '0;
        o_ctl.ev = sfd_pkg::EV_DATA;
        put      = 1'b0;
        put_data = i_byte;

        priority if (i_byte == sfd_pkg::FRAME_END) begin
            o_ctl.clr_fill = 1'b1;
            o_ctl.clr_esc  = 1'b1;
            o_ctl.set_sync = 1'b1;
            if (i_status.synced && i_status.fill_nonzero) begin
                o_ctl.emit     = 1'b1;
                o_ctl.ev       = sfd_pkg::EV_DONE;
                o_ctl.inc_done = 1'b1;
            end
        end else if (!i_status.synced) begin
            // hunting for the first end byte
        end else if (i_status.esc_pending) begin
            o_ctl.clr_esc = 1'b1;
            priority if (i_byte == sfd_pkg::TRANS_FRAME_END) begin
                put      = 1'b1;
                put_data = sfd_pkg::FRAME_END;
            end else if (i_byte == sfd_pkg::TRANS_FRAME_ESC) begin
                put      = 1'b1;
                put_data = sfd_pkg::FRAME_ESC;
            end else begin
                o_ctl.emit     = 1'b1;
                o_ctl.ev       = sfd_pkg::EV_DROP_ESC;
                o_ctl.inc_drop = 1'b1;
                o_ctl.clr_fill = 1'b1;
                o_ctl.clr_sync = 1'b1;
            end
        end else if (i_byte == sfd_pkg::FRAME_ESC) begin
            o_ctl.set_esc = 1'b1;
        end else begin
            put = 1'b1;
        end

        if (put) begin
            o_ctl.emit = 1'b1;
            if (i_status.fill_at_cap) begin
                o_ctl.ev       = sfd_pkg::EV_DROP_OVF;
                o_ctl.inc_drop = 1'b1;
                o_ctl.clr_fill = 1'b1;
                o_ctl.clr_esc  = 1'b1;
                o_ctl.clr_sync = 1'b1;
            end else begin
                o_ctl.ev       = sfd_pkg::EV_DATA;
                o_ctl.data     = put_data;
                o_ctl.inc_fill = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/slip_frame_decoder_core.sv
// channel   direction  handshake               payload
// in        sink       i_in_valid / o_in_stall  i_in_byte
// out       source     o_out_valid/i_out_stall  event, byte, index, length, counts
// cfg       sink       i_cfg_valid/o_cfg_ready  i_cfg_max_frame_len
//
// one byte per cycle while the result is not stalled: input register, one decode step, result register
// i_rst_n is synchronous: clears sync, fill, escape, counters, capacity to the smaller of FRAME_CAP_MAX and 4096
// a stalled result holds while one more byte is taken into the input register
// bytes that give no result pass through even while the result is stalled
module slip_frame_decoder_core #(
    parameter int unsigned FRAME_CAP_MAX = 4096,
    parameter int unsigned COUNT_BITS    = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [7:0]  o_out_byte,
    output logic [11:0] o_byte_index,
    output logic [12:0] o_frame_length,
    output logic [31:0] o_frame_count,
    output logic [31:0] o_drop_count,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_max_frame_len
);

    localparam int unsigned FILL_W  = $clog2(FRAME_CAP_MAX + 1);
    localparam int unsigned CMP_W   = (FILL_W > sfd_pkg::CFG_W) ? FILL_W : sfd_pkg::CFG_W;
    localparam int unsigned CNT_X_W = (COUNT_BITS > sfd_pkg::COUNT_OUT_W) ?
                                      COUNT_BITS : sfd_pkg::COUNT_OUT_W;
    localparam int unsigned CAP_RESET = (FRAME_CAP_MAX < sfd_pkg::CFG_MAX_LEN_RESET) ?
                                        FRAME_CAP_MAX : sfd_pkg::CFG_MAX_LEN_RESET;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;

    logic [FILL_W-1:0]     r_cap;
    logic [FILL_W-1:0]     r_fill,  n_fill;
    logic                  r_synced, n_synced;
    logic                  r_esc,   n_esc;
    logic [COUNT_BITS-1:0] r_done,  n_done;
    logic [COUNT_BITS-1:0] r_drop,  n_drop;

    logic                  r_out_valid;
    sfd_pkg::t_event       r_out_ev;
    logic [7:0]            r_out_byte;
    logic [11:0]           r_out_index;
    logic [12:0]           r_out_length;
    logic [31:0]           r_out_done;
    logic [31:0]           r_out_drop;

    sfd_pkg::t_frame_status status;
    sfd_pkg::t_step_ctl     ctl;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;
    logic [CMP_W-1:0]       cfg_ext;
    logic [CMP_W-1:0]       cap_limit;
    logic [CMP_W-1:0]       cap_sel;
    logic [CMP_W-1:0]       fill_ext;
    logic [CNT_X_W-1:0]     done_ext;
    logic [CNT_X_W-1:0]     drop_ext;

    // capacity is clamped once, when written
    assign cfg_ext   = CMP_W'(i_cfg_max_frame_len);
    assign cap_limit = CMP_W'(FRAME_CAP_MAX);
    assign cap_sel   = (cfg_ext > cap_limit) ? cap_limit : cfg_ext;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= FILL_W'(CAP_RESET);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= cap_sel[FILL_W-1:0];
        end
    end

    assign status.synced       = r_synced;
    assign status.esc_pending  = r_esc;
    assign status.fill_nonzero = (r_fill != '0);
    assign status.fill_at_cap  = (r_fill >= r_cap);

    sfd_byte_decode u_decode (
        .i_byte   (r_in_byte),
        .i_status (status),
        .o_ctl    (ctl)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (out_free || !ctl.emit);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_fill   = r_fill;
        n_synced = r_synced;
        n_esc    = r_esc;
        n_done   = r_done;
        n_drop   = r_drop;
        if (ctl.clr_fill) begin
            n_fill = '0;
        end else if (ctl.inc_fill) begin
            n_fill = r_fill + 1'b1;
        end
        if (ctl.set_sync) begin
            n_synced = 1'b1;
        end else if (ctl.clr_sync) begin
            n_synced = 1'b0;
        end
        if (ctl.set_esc) begin
            n_esc = 1'b1;
        end else if (ctl.clr_esc) begin
            n_esc = 1'b0;
        end
        if (ctl.inc_done) begin
            n_done = r_done + 1'b1;
        end
        if (ctl.inc_drop) begin
            n_drop = r_drop + 1'b1;
        end
    end

    assign fill_ext = CMP_W'(r_fill);
    assign done_ext = CNT_X_W'(n_done);
    assign drop_ext = CNT_X_W'(n_drop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_fill      <= '0;
            r_synced    <= 1'b0;
            r_esc       <= 1'b0;
            r_done      <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_fill   <= n_fill;
                r_synced <= n_synced;
                r_esc    <= n_esc;
                r_done   <= n_done;
                r_drop   <= n_drop;
            end
            if (advance && ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (advance && ctl.emit) begin
            r_out_ev     <= ctl.ev;
            r_out_byte   <= ctl.data;
            r_out_index  <= (ctl.ev == sfd_pkg::EV_DATA) ?
                            fill_ext[sfd_pkg::INDEX_W-1:0] : '0;
            r_out_length <= (ctl.ev == sfd_pkg::EV_DONE) ?
                            fill_ext[sfd_pkg::LENGTH_W-1:0] : '0;
            r_out_done   <= done_ext[sfd_pkg::COUNT_OUT_W-1:0];
            r_out_drop   <= drop_ext[sfd_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_res    = r_out_ev;
    assign o_out_byte     = r_out_byte;
    assign o_byte_index   = r_out_index;
    assign o_frame_length = r_out_length;
    assign o_frame_count  = r_out_done;
    assign o_drop_count   = r_out_drop;

`ifndef NO_ASSERTIONS
    // a capacity write may land below a partly filled frame, so only the ceiling bounds it
    a_fill_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FRAME_CAP_MAX))
        else $error("frame fill beyond capacity");

    a_unsynced_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_synced |-> (r_fill == '0) && !r_esc)
        else $error("fill or escape held while out of sync");

    a_done_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && ctl.emit && (ctl.ev == sfd_pkg::EV_DONE) |=> (r_out_length != '0))
        else $error("completed frame with zero length");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_drop_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && ctl.inc_drop |=> !r_synced && (r_drop == $past(r_drop) + 1'b1))
        else $error("drop not counted or sync kept");
`endif

endmodule

FILE: test/tb_slip_frame_decoder_core.sv
module tb_slip_frame_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAP_CEILING = 4096;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 110;

    typedef struct packed {
        sfd_pkg::t_event ev;
        logic [7:0]      data;
        logic [11:0]     idx;
        logic [12:0]     len;
        logic [31:0]     frames;
        logic [31:0]     drops;
    } t_slip_event;

    // how a directed row is checked: by the predictor, typed as no result,
    // typed as a result, or a capacity write
    typedef enum logic [1:0] {
        ROW_CHECK = 2'd0,
        ROW_QUIET = 2'd1,
        ROW_KNOWN = 2'd2,
        ROW_CAP   = 2'd3
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [12:0] value;
        t_slip_event res;
    } t_row;

    localparam t_slip_event NO_EVENT = '0;

    localparam t_row DIRECTED [0:27] = '{
        '{ROW_QUIET, 13'h041, NO_EVENT},
        '{ROW_QUIET, 13'h0DB, NO_EVENT},
        '{ROW_QUIET, 13'h0C0, NO_EVENT},
        '{ROW_QUIET, 13'h0C0, NO_EVENT},
        '{ROW_KNOWN, 13'h000, '{sfd_pkg::EV_DATA, 8'h00, 12'd0, 13'd0, 32'd0, 32'd0}},
        '{ROW_KNOWN, 13'h0FF, '{sfd_pkg::EV_DATA, 8'hFF, 12'd1, 13'd0, 32'd0, 32'd0}},
        '{ROW_CHECK, 13'h0DB, NO_EVENT},
        '{ROW_CHECK, 13'h0DC, NO_EVENT},
        '{ROW_CHECK, 13'h0DB, NO_EVENT},
        '{ROW_CHECK, 13'h0DD, NO_EVENT},
        '{ROW_KNOWN, 13'h0C0, '{sfd_pkg::EV_DONE, 8'h00, 12'd0, 13'd4, 32'd1, 32'd0}},
        '{ROW_CHECK, 13'h055, NO_EVENT},
        '{ROW_CHECK, 13'h0DB, NO_EVENT},
        '{ROW_KNOWN, 13'h0C0, '{sfd_pkg::EV_DONE, 8'h00, 12'd0, 13'd1, 32'd2, 32'd0}},
        '{ROW_QUIET, 13'h0DB, NO_EVENT},
        '{ROW_KNOWN, 13'h041, '{sfd_pkg::EV_DROP_ESC, 8'h00, 12'd0, 13'd0, 32'd2, 32'd1}},
        '{ROW_QUIET, 13'h042, NO_EVENT},
        '{ROW_QUIET, 13'h0C0, NO_EVENT},
        '{ROW_CHECK, 13'h0DC, NO_EVENT},
        '{ROW_CHECK, 13'h0C0, NO_EVENT},
        '{ROW_CAP,   13'd0,   NO_EVENT},
        '{ROW_QUIET, 13'h0C0, NO_EVENT},
        '{ROW_KNOWN, 13'h011, '{sfd_pkg::EV_DROP_OVF, 8'h00, 12'd0, 13'd0, 32'd3, 32'd2}},
        '{ROW_CAP,   13'd2,   NO_EVENT},
        '{ROW_QUIET, 13'h0C0, NO_EVENT},
        '{ROW_CHECK, 13'h001, NO_EVENT},
        '{ROW_CHECK, 13'h002, NO_EVENT},
        '{ROW_KNOWN, 13'h003, '{sfd_pkg::EV_DROP_OVF, 8'h00, 12'd0, 13'd0, 32'd3, 32'd3}}
    };

    logic        i_clk;
    logic        i_rst_n             = 1'b0;
    logic        i_in_valid          = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_in_byte           = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall         = 1'b0;
    logic [1:0]  o_event_res;
    logic [7:0]  o_out_byte;
    logic [11:0] o_byte_index;
    logic [12:0] o_frame_length;
    logic [31:0] o_frame_count;
    logic [31:0] o_drop_count;
    logic        i_cfg_valid         = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_max_frame_len = 13'd0;

    slip_frame_decoder_core dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_in_byte           (i_in_byte),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_event_res         (o_event_res),
        .o_out_byte          (o_out_byte),
        .o_byte_index        (o_byte_index),
        .o_frame_length      (o_frame_length),
        .o_frame_count       (o_frame_count),
        .o_drop_count        (o_drop_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_max_frame_len (i_cfg_max_frame_len)
    );

    // predictor state
    int          mdl_cap;
    int          mdl_fill;
    bit          mdl_esc;
    bit          mdl_synced;
    logic [31:0] mdl_frames;
    logic [31:0] mdl_drops;

    t_slip_event awaited_events[$];

    int    mismatches    = 0;
    int    checked       = 0;
    int    sent_items    = 0;
    int    cap_writes    = 0;
    int    burst_left    = 0;
    bit    sender_gapless = 1'b0;
    bit    hold_req      = 1'b0;
    int    hold_left     = 0;
    int    stall_mode    = 0;
    int    mode_left     = 0;
    int    cycle_count   = 0;
    int    n_done        = 0;
    int    n_ovf         = 0;
    int    n_esc         = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit store_payload_byte(input logic [7:0] b, output t_slip_event r);
        int lim;
        lim = (mdl_cap > CAP_CEILING) ? CAP_CEILING : mdl_cap;
        r = '0;
        if (mdl_fill >= lim) begin
            mdl_drops  = mdl_drops + 1;
            mdl_fill   = 0;
            mdl_esc    = 1'b0;
            mdl_synced = 1'b0;
            r.ev       = sfd_pkg::EV_DROP_OVF;
        end else begin
            r.ev   = sfd_pkg::EV_DATA;
            r.data = b;
            r.idx  = mdl_fill[11:0];
            mdl_fill++;
        end
        r.frames = mdl_frames;
        r.drops  = mdl_drops;
        return 1'b1;
    endfunction

    function automatic bit decode_line_byte(input logic [7:0] b, output t_slip_event r);
        r = '0;
        if (b == sfd_pkg::FRAME_END) begin
            if (mdl_synced && mdl_fill > 0) begin
                mdl_frames = mdl_frames + 1;
                r.ev       = sfd_pkg::EV_DONE;
                r.len      = mdl_fill[12:0];
                r.frames   = mdl_frames;
                r.drops    = mdl_drops;
                mdl_fill   = 0;
                mdl_esc    = 1'b0;
                return 1'b1;
            end
            mdl_synced = 1'b1;
            mdl_fill   = 0;
            mdl_esc    = 1'b0;
            return 1'b0;
        end
        if (!mdl_synced)
            return 1'b0;
        if (mdl_esc) begin
            mdl_esc = 1'b0;
            if (b == sfd_pkg::TRANS_FRAME_END)
                return store_payload_byte(sfd_pkg::FRAME_END, r);
            if (b == sfd_pkg::TRANS_FRAME_ESC)
                return store_payload_byte(sfd_pkg::FRAME_ESC, r);
            mdl_drops  = mdl_drops + 1;
            mdl_fill   = 0;
            mdl_synced = 1'b0;
            r.ev       = sfd_pkg::EV_DROP_ESC;
            r.frames   = mdl_frames;
            r.drops    = mdl_drops;
            return 1'b1;
        end
        if (b == sfd_pkg::FRAME_ESC) begin
            mdl_esc = 1'b1;
            return 1'b0;
        end
        return store_payload_byte(b, r);
    endfunction

    // one input transaction, then the expectation it leaves behind
    task automatic send_line_byte(input logic [7:0] b, input t_row_kind kind,
                                  input t_slip_event known);
        t_slip_event r;
        bit          has;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 30);
            if (!sender_gapless) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent_items++;
        has = decode_line_byte(b, r);
        if (kind == ROW_KNOWN)
            awaited_events.push_back(known);
        else if (kind == ROW_CHECK && has)
            awaited_events.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_line_byte(b, ROW_CHECK, NO_EVENT);
    endtask

    // capacity is only changed with the block idle
    task automatic set_capacity(input logic [12:0] v);
        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid         <= 1'b1;
        i_cfg_max_frame_len <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mdl_cap    = v;
        burst_left = 0;
        cap_writes++;
    endtask

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 7))
            0: return sfd_pkg::FRAME_END;
            1: return sfd_pkg::FRAME_ESC;
            2: return sfd_pkg::TRANS_FRAME_END;
            3: return sfd_pkg::TRANS_FRAME_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // payload byte with proper escaping
    task automatic send_encoded(input logic [7:0] b);
        if (b == sfd_pkg::FRAME_END) begin
            send_byte(sfd_pkg::FRAME_ESC);
            send_byte(sfd_pkg::TRANS_FRAME_END);
        end else if (b == sfd_pkg::FRAME_ESC) begin
            send_byte(sfd_pkg::FRAME_ESC);
            send_byte(sfd_pkg::TRANS_FRAME_ESC);
        end else begin
            send_byte(b);
        end
    endtask

    task automatic send_frame(input int cap);
        int lim;
        int len;
        lim = ((cap > CAP_CEILING) ? CAP_CEILING : cap) + 2;
        if (lim > 24)
            lim = 24;
        len = $urandom_range(0, lim);
        if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        send_byte(sfd_pkg::FRAME_END);
        if ($urandom_range(0, 7) == 0)
            send_byte(sfd_pkg::FRAME_END);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 29) == 0) begin
                // broken escape, sometimes accidentally valid
                send_byte(sfd_pkg::FRAME_ESC);
                send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_encoded(pick_payload());
            end
        end
        if ($urandom_range(0, 19) == 0)
            send_byte(sfd_pkg::FRAME_ESC);
        if ($urandom_range(0, 9) != 0)
            send_byte(sfd_pkg::FRAME_END);
    endtask

    task automatic run_phase(input logic [12:0] cap, input bit pressure);
        int start;
        set_capacity(cap);
        if (pressure) begin
            sender_gapless = 1'b1;
            hold_req       = 1'b1;
        end
        start = sent_items;
        while (sent_items - start < PHASE_ITEMS)
            send_frame(cap);
        sender_gapless = 1'b0;
    endtask

    // result side: checks and its own stall pattern
    always @(posedge i_clk) begin
        t_slip_event got;
        t_slip_event exp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{sfd_pkg::t_event'(o_event_res), o_out_byte, o_byte_index,
                    o_frame_length, o_frame_count, o_drop_count};
            if (awaited_events.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual ev=%0d byte=%h idx=%0d len=%0d",
                         $time, got.ev, got.data, got.idx, got.len);
            end else begin
                exp = awaited_events.pop_front();
                checked++;
                case (exp.ev)
                    sfd_pkg::EV_DONE:     n_done++;
                    sfd_pkg::EV_DROP_OVF: n_ovf++;
                    sfd_pkg::EV_DROP_ESC: n_esc++;
                    default: ;
                endcase
                if (got !== exp) begin
                    mismatches++;
                    $display("%0t: mismatch expected ev=%0d byte=%h idx=%0d len=%0d %s",
                             $time, exp.ev, exp.data, exp.idx, exp.len,
                             $sformatf("fc=%0d dc=%0d", exp.frames, exp.drops));
                    $display("%0t:          actual   ev=%0d byte=%h idx=%0d len=%0d %s",
                             $time, got.ev, got.data, got.idx, got.len,
                             $sformatf("fc=%0d dc=%0d", got.frames, got.drops));
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 150);
        end
        mode_left--;
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        mdl_cap    = sfd_pkg::CFG_MAX_LEN_RESET;
        mdl_fill   = 0;
        mdl_esc    = 1'b0;
        mdl_synced = 1'b0;
        mdl_frames = '0;
        mdl_drops  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == ROW_CAP)
                set_capacity(DIRECTED[i].value);
            else
                send_line_byte(DIRECTED[i].value[7:0], DIRECTED[i].kind, DIRECTED[i].res);
        end

        run_phase(13'd1, 1'b0);
        run_phase(13'd8191, 1'b0);
        run_phase(13'd0, 1'b0);
        run_phase(13'd4096, 1'b1);
        run_phase(13'd3, 1'b0);
        run_phase(13'($urandom_range(1, 40)), 1'b0);
        run_phase(13'd4097, 1'b0);
        run_phase(13'($urandom_range(1, 4096)), 1'b0);

        i_in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d line bytes over %0d capacity writes, %0d results checked",
                 sent_items, cap_writes, checked);
        $display("frames completed %0d, overflow drops %0d, escape drops %0d",
                 n_done, n_ovf, n_esc);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_byte_decode.sv
rtl/core/slip_frame_decoder_core.sv
test/tb_slip_frame_decoder_core.sv
